>>> design/bitmap_chunk_pattern_encoder_core_macros.svh
// ----------------------------------------------------------------------------
// Bitmap chunk pattern encoder: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during rst.
// ----------------------------------------------------------------------------
`ifndef BITMAP_CHUNK_PATTERN_ENCODER_CORE_MACROS_SVH
`define BITMAP_CHUNK_PATTERN_ENCODER_CORE_MACROS_SVH

// same-cycle implication
`define BCPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// bcpe_pkg
// Widths, mode codes, result type and bit helpers for the chunk encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpe_pkg;

  localparam int CHUNK_BITS_DEF = 8;
  localparam int CHUNK_W        = 8;
  localparam int PAY_W          = 8;
  localparam int LEN_W          = 4;
  localparam int MODE_W         = 2;
  localparam int POS_W          = $clog2(CHUNK_W);

  localparam logic [MODE_W-1:0] MODE_ZERO_TWO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WIDE     = 2'd2;

  typedef struct packed {
    logic             matched;
    logic [PAY_W-1:0] payload;
    logic [LEN_W-1:0] payload_length;
    logic             row_done;
  } bcpe_result_t;

  function automatic logic is_one_bit(input logic [CHUNK_W-1:0] x);
    return (x != '0) && ((x & (x - CHUNK_W'(1))) == '0);
  endfunction

  // position of the lowest set bit, 0 for an empty word
  function automatic logic [POS_W-1:0] low_bit_pos(input logic [CHUNK_W-1:0] x);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (x[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/bcpe_encode.sv
// ----------------------------------------------------------------------------
// bcpe_encode
// Pattern match and code selection for one chunk, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_encode #(
  parameter int CHUNK_BITS = bcpe_pkg::CHUNK_BITS_DEF
) (
  input  wire logic [bcpe_pkg::MODE_W-1:0]  mode,
  input  wire logic [bcpe_pkg::CHUNK_W-1:0] chunk,
  input  wire logic                         row_end,
  output logic                              emit,
  output bcpe_pkg::bcpe_result_t            result
);
  import bcpe_pkg::*;

  localparam int CW     = (CHUNK_BITS < CHUNK_W) ? CHUNK_BITS : CHUNK_W;
  localparam int LG     = $clog2(CHUNK_BITS + 1) - 1;
  localparam int CODE_W = LG + 1;

  localparam logic [CHUNK_W-1:0] CMASK       = CHUNK_W'((64'd1 << CW) - 64'd1);
  localparam logic [CODE_W-1:0]  WIDE_BASE   = CODE_W'(CHUNK_BITS);
  localparam logic [CODE_W-1:0]  NARROW_MASK = CODE_W'((64'd1 << LG) - 64'd1);

  logic [CHUNK_W-1:0] c;
  logic [CHUNK_W-1:0] hi;
  logic               c_one;
  logic               hi_one;
  logic [POS_W-1:0]   pos_c;
  logic [POS_W-1:0]   pos_hi;
  logic               hit;
  logic [CODE_W-1:0]  code;
  logic [LEN_W-1:0]   len;

  always_comb begin
    c      = chunk & CMASK;
    hi     = {c[CHUNK_W-1:1], 1'b0};
    c_one  = is_one_bit(c);
    hi_one = is_one_bit(hi);
    pos_c  = low_bit_pos(c);
    pos_hi = low_bit_pos(hi);

    emit = 1'b1;
    hit  = 1'b0;
    code = '0;
    len  = LEN_W'(LG);

    case (mode)
      MODE_SINGLE: begin
        if (c_one) begin
          hit  = 1'b1;
          code = CODE_W'(pos_c);
        end
      end
      MODE_ZERO_TWO, MODE_WIDE: begin
        if (mode == MODE_WIDE) begin
          len = LEN_W'(LG + 1);
        end
        if (c == '0) begin
          hit = 1'b1;
        end else if (c[0] && hi_one) begin
          hit  = 1'b1;
          code = CODE_W'(pos_hi);
        end else if ((mode == MODE_WIDE) && c_one) begin
          // lone bit in the wide model sits above the chunk width
          hit  = 1'b1;
          code = WIDE_BASE + CODE_W'(pos_c);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    // narrow models keep LG code bits
    if (mode != MODE_WIDE) begin
      code = code & NARROW_MASK;
    end

    result.matched        = hit;
    result.payload        = hit ? PAY_W'(code) : PAY_W'(c);
    result.payload_length = hit ? len : LEN_W'(CHUNK_BITS);
    result.row_done       = row_end;
  end

endmodule

`default_nettype wire

>>> design/bitmap_chunk_pattern_encoder_core.sv
// ----------------------------------------------------------------------------
// bitmap_chunk_pattern_encoder_core
// Codes adjacency-matrix row chunks as short pattern codes or raw bits.
// ----------------------------------------------------------------------------
// One chunk is taken per cycle while input ready is high. Its result goes
// through an input register, the pattern coder, then a result register.
// The input register refills when empty or when its item leaves, so a
// result-side stall holds one item in each and input ready drops only when
// both are full. Mode 3 takes items and drops them without a result. The mode
// register is written with cfg_we; write it only while no item is in flight.
`default_nettype none

module bitmap_chunk_pattern_encoder_core #(
  parameter int CHUNK_BITS = bcpe_pkg::CHUNK_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [bcpe_pkg::MODE_W-1:0]  cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bcpe_pkg::CHUNK_W-1:0] chunk,
  input  wire logic                         row_end,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              matched,
  output logic [bcpe_pkg::PAY_W-1:0]        payload,
  output logic [bcpe_pkg::LEN_W-1:0]        payload_length,
  output logic                              row_done
);
  import bcpe_pkg::*;

  logic [MODE_W-1:0]  mode;
  logic               s1_valid;
  logic [CHUNK_W-1:0] s1_chunk;
  logic               s1_row_end;
  bcpe_result_t       out_res;

  logic               emit;
  bcpe_result_t       enc_res;
  logic               out_free;
  logic               s1_leave;

  bcpe_encode #(
    .CHUNK_BITS(CHUNK_BITS)
  ) u_encode (
    .mode   (mode),
    .chunk  (s1_chunk),
    .row_end(s1_row_end),
    .emit   (emit),
    .result (enc_res)
  );

  assign out_free = !out_valid || out_ready;
  // a dropped item leaves without needing the result register
  assign s1_leave = s1_valid && (out_free || !emit);
  assign in_ready = !s1_valid || s1_leave;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ZERO_TWO;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_chunk   <= chunk;
      s1_row_end <= row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && emit) begin
      out_res <= enc_res;
    end
  end

  assign matched        = out_res.matched;
  assign payload        = out_res.payload;
  assign payload_length = out_res.payload_length;
  assign row_done       = out_res.row_done;

endmodule

`default_nettype wire

>>> design/bcpe_checker.sv
// ----------------------------------------------------------------------------
// bcpe_checker
// Port-level assertions for the chunk pattern encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_chunk_pattern_encoder_core_macros.svh"

module bcpe_checker #(
  parameter int CHUNK_BITS = bcpe_pkg::CHUNK_BITS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         matched,
  input wire logic [bcpe_pkg::PAY_W-1:0]   payload,
  input wire logic [bcpe_pkg::LEN_W-1:0]   payload_length,
  input wire logic                         row_done
);
  import bcpe_pkg::*;

  // stalled result holds
  `BCPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(payload) && $stable(matched) && $stable(row_done),
    "stalled result changed")

  // an empty result register never blocks input
  `BCPE_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready,
    "input stalled with result register empty")

  // raw chunks always carry the full chunk length
  `BCPE_ASSERT_NOW(a_raw_length, out_valid && !matched,
    payload_length == LEN_W'(CHUNK_BITS), "raw item with wrong length")

  // a code never spills past its length
  `BCPE_ASSERT_NOW(a_code_fits, out_valid && matched,
    (payload >> payload_length) == '0, "pattern code wider than its length")

endmodule

bind bitmap_chunk_pattern_encoder_core bcpe_checker #(
  .CHUNK_BITS(CHUNK_BITS)
) u_bcpe_checker (.*);

`default_nettype wire
